[rtl/dsga_pkg.sv]
`default_nettype none

package dsga_pkg;

    // grid store geometry
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int SWEEP_W  = $clog2(CELLS + 2);

    // field widths
    localparam int CELL_W     = 17;
    localparam int POS_W      = 10;
    localparam int SIZE_W     = 6;
    localparam int GRID_W     = 7;
    localparam int RATE_W     = 16;
    localparam int FT_W       = 16;
    localparam int FAC_W      = 31;
    localparam int PROD_W     = FAC_W + CELL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = $clog2(POS_W + 1);

    // fixed-point constants
    localparam logic [CELL_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [FAC_W-1:0]  ONE_Q30   = 31'h4000_0000;
    localparam int                DEP_SHIFT = 14;
    localparam int                FAC_SHIFT = 30;

    // register reset values
    localparam logic [SIZE_W-1:0] CELL_SIZE_RST    = 6'd12;
    localparam logic [GRID_W-1:0] GRID_COLS_RST    = 7'd53;
    localparam logic [GRID_W-1:0] GRID_ROWS_RST    = 7'd40;
    localparam logic [RATE_W-1:0] DECAY_RATE_RST   = 16'd1311;
    localparam logic [RATE_W-1:0] DEPOSIT_RATE_RST = 16'd8192;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_DEPOSIT = 2'd1,
        ACT_QUERY   = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_CELL_SIZE    = 3'd2,
        REG_GRID_COLS    = 3'd3,
        REG_GRID_ROWS    = 3'd4,
        REG_DECAY_RATE   = 3'd5,
        REG_DEPOSIT_RATE = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TK_FACT,
        ST_TK_DEP,
        ST_TK_SWEEP,
        ST_DIV_X,
        ST_DIV_Y,
        ST_LOOK,
        ST_RD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic              start;
        logic [POS_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

[rtl/dsga_div.sv]
`default_nettype none

module dsga_div
    import dsga_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  div_req_t  req,
    output div_rsp_t  rsp
);

    logic                 run_reg,  run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [SIZE_W-1:0]    rem_reg,  rem_next;
    logic [POS_W-1:0]     quo_reg,  quo_next;
    logic [SIZE_W-1:0]    dvs_reg,  dvs_next;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W:0]      diff;
    logic                 fits;

    // one restoring step: bring down the next dividend bit
    assign trial = {rem_reg, quo_reg[POS_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    // step sequencing
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = DIV_CNT_W'(POS_W);
            rem_next = '0;
            quo_next = req.dividend;
            dvs_next = req.divisor;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            quo_next = {quo_reg[POS_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // partial remainder and quotient
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/dsga_mul.sv]
`default_nettype none

module dsga_mul
    import dsga_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [FAC_W-1:0]  op_a,
    input  wire logic [CELL_W-1:0] op_b,
    output logic      [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg, prod_next;

    // shared multiplier, product registered every cycle
    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[rtl/dsga_store.sv]
`default_nettype none

module dsga_store
    import dsga_pkg::*;
(
    input  wire logic              clk,
    input  mem_req_t               req,
    output logic      [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/decaying_saturating_grid_accumulator.sv]
`default_nettype none

// Grid of saturating Q1.16 cells (1.0 = 65536) that decays on a tick, takes deposits
// and answers queries. A request is taken when start is high and busy is low; exactly
// one result follows, shown on cell_value/in_grid for the single cycle that done is
// high, and it must be captured then since the block cannot be stalled. A deposit or
// query runs two passes of the one-bit-a-step divider (x then y offset over cell_size,
// a load and 10 steps each) and then reads the cell it hits, which a deposit writes
// back; a point left of or above the origin, a zero cell_size or an unused action code
// goes straight to done. In a tick every cell goes through the one shared multiplier,
// one cell a cycle, over the store's read and write ports. After reset, and after a
// write that changes grid_cols or grid_rows, the store is cleared one cell a cycle with
// busy high. Configuration writes are always taken (cfg_ready is high) and belong in
// times when no request is in flight.

module decaying_saturating_grid_accumulator
    import dsga_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            action,
    input  wire logic [POS_W-1:0]      pos_x,
    input  wire logic [POS_W-1:0]      pos_y,
    input  wire logic [FT_W-1:0]       frame_time,
    output logic                       done,
    output logic      [CELL_W-1:0]     cell_value,
    output logic                       in_grid,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [POS_W-1:0]  origin_x_reg,     origin_x_next;
    logic [POS_W-1:0]  origin_y_reg,     origin_y_next;
    logic [SIZE_W-1:0] cell_size_reg,    cell_size_next;
    logic [GRID_W-1:0] grid_cols_reg,    grid_cols_next;
    logic [GRID_W-1:0] grid_rows_reg,    grid_rows_next;
    logic [RATE_W-1:0] decay_rate_reg,   decay_rate_next;
    logic [RATE_W-1:0] deposit_rate_reg, deposit_rate_next;
    logic              clear_req;

    // sequencer and datapath
    state_t             state_reg, state_next;
    logic [SWEEP_W-1:0] cnt_reg,    cnt_next;
    logic [CELL_W-1:0]  dep_reg,    dep_next;
    action_t            act_reg,    act_next;
    logic [FT_W-1:0]    ft_reg,     ft_next;
    logic [POS_W-1:0]   offy_reg,   offy_next;
    logic [POS_W-1:0]   gx_reg,     gx_next;
    logic [POS_W-1:0]   gy_reg,     gy_next;
    logic [FAC_W-1:0]   factor_reg, factor_next;
    logic [CELL_W-1:0]  value_reg,  value_next;
    logic               in_grid_reg, in_grid_next;

    mem_req_t           mem_req;
    logic [CELL_W-1:0]  rdata;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic [FAC_W-1:0]   mul_a;
    logic [CELL_W-1:0]  mul_b;
    logic [PROD_W-1:0]  prod;

    logic                      accept;
    logic                      outside_pre;
    logic                      cell_hit;
    logic [ADDR_W-1:0]         cell_addr;
    logic [SWEEP_W-1:0]        sweep_wr;
    logic [CELL_W:0]           sum;
    logic [CELL_W-1:0]         sat_sum;
    logic [PROD_W-DEP_SHIFT-1:0] dep_full;

    assign cfg_ready = 1'b1;
    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign cell_value = value_reg;
    assign in_grid    = in_grid_reg;

    // register writes, grid size change starts a clear
    always_comb
    begin
        origin_x_next     = origin_x_reg;
        origin_y_next     = origin_y_reg;
        cell_size_next    = cell_size_reg;
        grid_cols_next    = grid_cols_reg;
        grid_rows_next    = grid_rows_reg;
        decay_rate_next   = decay_rate_reg;
        deposit_rate_next = deposit_rate_reg;
        clear_req         = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:     origin_x_next  = cfg_data[POS_W-1:0];
                REG_ORIGIN_Y:     origin_y_next  = cfg_data[POS_W-1:0];
                REG_CELL_SIZE:    cell_size_next = cfg_data[SIZE_W-1:0];
                REG_GRID_COLS:
                begin
                    grid_cols_next = cfg_data[GRID_W-1:0];
                    clear_req      = (cfg_data[GRID_W-1:0] != grid_cols_reg);
                end
                REG_GRID_ROWS:
                begin
                    grid_rows_next = cfg_data[GRID_W-1:0];
                    clear_req      = (cfg_data[GRID_W-1:0] != grid_rows_reg);
                end
                REG_DECAY_RATE:   decay_rate_next   = cfg_data[RATE_W-1:0];
                REG_DEPOSIT_RATE: deposit_rate_next = cfg_data[RATE_W-1:0];
                default:          clear_req = 1'b0;
            endcase
        end
    end

    // point checks and cell address
    assign outside_pre = (pos_x < origin_x_reg) || (pos_y < origin_y_reg) ||
                         (cell_size_reg == '0);
    assign cell_hit    = (gx_reg < POS_W'(grid_cols_reg)) && (gx_reg < POS_W'(MAX_COLS)) &&
                         (gy_reg < POS_W'(grid_rows_reg)) && (gy_reg < POS_W'(MAX_ROWS));
    assign cell_addr   = ADDR_W'(gy_reg) * ADDR_W'(MAX_COLS) + ADDR_W'(gx_reg);
    assign sweep_wr    = cnt_reg - SWEEP_W'(2);

    // saturating add of the latched deposit
    assign sum     = {1'b0, rdata} + {1'b0, dep_reg};
    assign sat_sum = (sum > {1'b0, ONE_Q16}) ? ONE_Q16 : sum[CELL_W-1:0];

    // deposit per frame, clamped to 1.0
    assign dep_full = prod[PROD_W-1:DEP_SHIFT];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == SWEEP_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_TICK)
                    begin
                        state_next = ST_TK_FACT;
                    end
                    else if ((action == ACT_DEPOSIT || action == ACT_QUERY) && !outside_pre)
                    begin
                        state_next = ST_DIV_X;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_TK_FACT:  state_next = ST_TK_DEP;
            ST_TK_DEP:   state_next = ST_TK_SWEEP;
            ST_TK_SWEEP:
            begin
                if (cnt_reg == SWEEP_W'(CELLS + 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:     state_next = cell_hit ? ST_RD : ST_DONE;
            ST_RD:       state_next = ST_DONE;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
        if (clear_req)
        begin
            state_next = ST_CLEAR;
        end
    end

    // sequencer outputs and datapath updates
    always_comb
    begin
        mem_req          = '0;
        div_req          = '0;
        div_req.divisor  = cell_size_reg;
        mul_a            = factor_reg;
        mul_b            = rdata;
        dep_next         = dep_reg;
        act_next         = act_reg;
        ft_next          = ft_reg;
        offy_next        = offy_reg;
        gx_next          = gx_reg;
        gy_next          = gy_reg;
        factor_next      = factor_reg;
        value_next       = value_reg;
        in_grid_next     = in_grid_reg;

        // sweep counter runs while clearing or decaying
        if (!clear_req && state_next == state_reg &&
            (state_reg == ST_CLEAR || state_reg == ST_TK_SWEEP))
        begin
            cnt_next = cnt_reg + SWEEP_W'(1);
        end
        else
        begin
            cnt_next = '0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg[ADDR_W-1:0];
                mem_req.wdata = '0;
            end
            ST_IDLE:
            begin
                mul_a = FAC_W'(frame_time);
                mul_b = CELL_W'(decay_rate_reg);
                if (accept)
                begin
                    act_next     = action_t'(action);
                    ft_next      = frame_time;
                    offy_next    = pos_y - origin_y_reg;
                    value_next   = '0;
                    in_grid_next = 1'b0;
                    if ((action == ACT_DEPOSIT || action == ACT_QUERY) && !outside_pre)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = pos_x - origin_x_reg;
                    end
                end
            end
            ST_TK_FACT:
            begin
                mul_a = FAC_W'(ft_reg);
                mul_b = CELL_W'(deposit_rate_reg);
                if (prod >= PROD_W'(ONE_Q30))
                begin
                    factor_next = '0;
                end
                else
                begin
                    factor_next = ONE_Q30 - prod[FAC_W-1:0];
                end
            end
            ST_TK_DEP:
            begin
                if (dep_full > (PROD_W - DEP_SHIFT)'(ONE_Q16))
                begin
                    dep_next = ONE_Q16;
                end
                else
                begin
                    dep_next = prod[DEP_SHIFT+CELL_W-1:DEP_SHIFT];
                end
            end
            ST_TK_SWEEP:
            begin
                // read cell n, scale cell n-1, write back cell n-2
                mem_req.raddr = cnt_reg[ADDR_W-1:0];
                mem_req.we    = (cnt_reg >= SWEEP_W'(2));
                mem_req.waddr = sweep_wr[ADDR_W-1:0];
                mem_req.wdata = prod[FAC_SHIFT+CELL_W-1:FAC_SHIFT];
            end
            ST_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    gx_next          = div_rsp.quotient;
                    div_req.start    = 1'b1;
                    div_req.dividend = offy_reg;
                end
            end
            ST_DIV_Y:
            begin
                if (div_rsp.done)
                begin
                    gy_next = div_rsp.quotient;
                end
            end
            ST_LOOK:
            begin
                mem_req.raddr = cell_addr;
            end
            ST_RD:
            begin
                in_grid_next = 1'b1;
                if (act_reg == ACT_DEPOSIT)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = cell_addr;
                    mem_req.wdata = sat_sum;
                    value_next    = sat_sum;
                end
                else
                begin
                    value_next = rdata;
                end
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            cnt_reg          <= '0;
            dep_reg          <= '0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            cell_size_reg    <= CELL_SIZE_RST;
            grid_cols_reg    <= GRID_COLS_RST;
            grid_rows_reg    <= GRID_ROWS_RST;
            decay_rate_reg   <= DECAY_RATE_RST;
            deposit_rate_reg <= DEPOSIT_RATE_RST;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            dep_reg          <= dep_next;
            origin_x_reg     <= origin_x_next;
            origin_y_reg     <= origin_y_next;
            cell_size_reg    <= cell_size_next;
            grid_cols_reg    <= grid_cols_next;
            grid_rows_reg    <= grid_rows_next;
            decay_rate_reg   <= decay_rate_next;
            deposit_rate_reg <= deposit_rate_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        ft_reg      <= ft_next;
        offy_reg    <= offy_next;
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        factor_reg  <= factor_next;
        value_reg   <= value_next;
        in_grid_reg <= in_grid_next;
    end

    dsga_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    dsga_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    dsga_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // a taken request always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    // results last a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // cell values never exceed 1.0
    a_value_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cell_value <= ONE_Q16)
        else $error("cell value above saturation");

    // a point off the grid reports zero
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !in_grid |-> cell_value == '0)
        else $error("nonzero value for a point off the grid");

endmodule

`default_nettype wire
